// ===== rtl/core/header_trailer_frame_sync_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the header/trailer frame synchroniser
// Shared property templates used by the RTL checks of this block.
// ----------------------------------------------------------------------------
`ifndef HEADER_TRAILER_FRAME_SYNC_ASSERT_SVH
`define HEADER_TRAILER_FRAME_SYNC_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define HTFS_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("htfs: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define HTFS_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("htfs: next-cycle check failed");

`endif

// ===== rtl/core/htfs_pkg.sv =====
// ----------------------------------------------------------------------------
// htfs_pkg
// Types and constants shared by the frame synchroniser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package htfs_pkg;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 6;
  localparam int TRAIL_W  = 16;
  localparam int TDATA_W  = 16;

  // Window size default
  localparam int FRAME_BYTES_DEFAULT = 32;

  // Input queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_HEADER  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_TRAILER = 1'b1;

  localparam logic [BYTE_W-1:0]  HEADER_RESET  = 8'h5A;
  localparam logic [TRAIL_W-1:0] TRAILER_RESET = 16'hFFFB;

  // Live configuration values
  typedef struct packed {
    logic [BYTE_W-1:0]  header_value;
    logic [TRAIL_W-1:0] trailer_value;
  } cfg_t;

  // Head of the input queue
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } qhead_t;

endpackage

`default_nettype wire

// ===== rtl/core/htfs_front.sv =====
// ----------------------------------------------------------------------------
// htfs_front
// Input side: takes received bytes and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module htfs_front (
  input  wire                              clk,
  input  wire                              rst,
  input  wire  [htfs_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire                              q_pop,
  output htfs_pkg::qhead_t                 qhead
);

  localparam int QW = htfs_pkg::QPTR_W;
  localparam int CW = htfs_pkg::QCNT_W;
  localparam logic [CW-1:0] Q_FULL = CW'(htfs_pkg::QUEUE_DEPTH);

  logic [htfs_pkg::BYTE_W-1:0] slots [htfs_pkg::QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;

  // Request handshake
  assign s_tready = (count != Q_FULL);
  assign push     = s_tvalid && s_tready;

  // Queue head towards the back end
  assign qhead.valid = (count != '0);
  assign qhead.data  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= s_tdata;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/htfs_back.sv =====
// ----------------------------------------------------------------------------
// htfs_back
// Window engine: stores bytes, checks header and trailer, reads frames out.
// ----------------------------------------------------------------------------
`default_nettype none

`include "header_trailer_frame_sync_assert.svh"

module htfs_back #(
  parameter int FRAME_BYTES = htfs_pkg::FRAME_BYTES_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst,
  input  htfs_pkg::cfg_t                   cfg,
  input  htfs_pkg::qhead_t                 qhead,
  output logic                             q_pop,
  output logic [htfs_pkg::TDATA_W-1:0]     m_tdata,   // [7:0] frame_byte, [13:8] byte_index
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic                             m_tlast    // last_of_frame
);

  localparam int PTR_W = $clog2(FRAME_BYTES);
  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int BW    = htfs_pkg::BYTE_W;
  localparam int IW    = htfs_pkg::INDEX_W;
  localparam int PAD_W = htfs_pkg::TDATA_W - BW - IW;
  localparam logic [CNT_W-1:0] FULL     = CNT_W'(FRAME_BYTES);
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(FRAME_BYTES - 1);
  localparam logic [SUM_W-1:0] WRAP     = SUM_W'(FRAME_BYTES);

  // Engine states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_LOAD  = 2'd3;

  logic [1:0]           state;
  logic [PTR_W-1:0]     oldest;
  logic [CNT_W-1:0]     fill;
  logic [PTR_W-1:0]     idx;
  logic [BW-1:0]        prev_byte;
  logic [2*BW-1:0]      tail;
  logic [BW-1:0]        rd_data;
  logic [BW-1:0]        window_store [FRAME_BYTES];
  logic [BW-1:0]        out_byte;
  logic [IW-1:0]        out_index;
  logic                 out_last;

  logic [SUM_W-1:0]     wr_sum;
  logic [SUM_W-1:0]     rd_sum;
  logic [PTR_W-1:0]     wr_addr;
  logic [PTR_W-1:0]     rd_wrap;
  logic [PTR_W-1:0]     rd_addr;
  logic [PTR_W-1:0]     oldest_inc;
  logic [CNT_W-1:0]     fill_inc;
  logic                 frame_full;
  logic                 rd_en;
  logic                 out_free;
  logic                 load;
  logic                 idx_last;
  logic                 match;

  // Circular addressing into the window
  assign wr_sum     = SUM_W'(oldest) + SUM_W'(fill);
  assign wr_addr    = (wr_sum >= WRAP) ? PTR_W'(wr_sum - WRAP) : PTR_W'(wr_sum);
  assign rd_sum     = SUM_W'(oldest) + SUM_W'(idx);
  assign rd_wrap    = (rd_sum >= WRAP) ? PTR_W'(rd_sum - WRAP) : PTR_W'(rd_sum);
  assign oldest_inc = (oldest == LAST_POS) ? '0 : oldest + 1'b1;

  // Byte intake and frame check
  assign q_pop      = (state == ST_IDLE) && qhead.valid;
  assign fill_inc   = fill + 1'b1;
  assign frame_full = (fill_inc == FULL);
  assign match      = (rd_data == cfg.header_value) && (tail == cfg.trailer_value);

  // Read port: header byte on window fill, frame bytes during readout
  assign rd_en   = (q_pop && frame_full) || (state == ST_READ);
  assign rd_addr = (state == ST_READ) ? rd_wrap : oldest;

  // Output register handshake
  assign out_free = !m_tvalid || m_tready;
  assign load     = (state == ST_LOAD) && out_free;
  assign idx_last = (idx == LAST_POS);

  assign m_tdata = {{PAD_W{1'b0}}, out_index, out_byte};
  assign m_tlast = out_last;

  // Window memory
  always_ff @(posedge clk) begin
    if (q_pop) begin
      window_store[wr_addr] <= qhead.data;
    end
    if (rd_en) begin
      rd_data <= window_store[rd_addr];
    end
  end

  // Trailer capture and output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      prev_byte <= qhead.data;
      if (frame_full) begin
        tail <= {qhead.data, prev_byte};
      end
    end
    if (load) begin
      out_byte  <= rd_data;
      out_index <= IW'(idx);
      out_last  <= idx_last;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      oldest   <= '0;
      fill     <= '0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            fill <= fill_inc;
            if (frame_full) begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (match) begin
            idx   <= '0;
            state <= ST_READ;
          end else begin
            // drop the oldest byte and slide the search on
            oldest <= oldest_inc;
            fill   <= fill - 1'b1;
            state  <= ST_IDLE;
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            if (idx_last) begin
              fill   <= '0;
              oldest <= '0;
              state  <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Checks
  `HTFS_ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, fill <= FULL)
  `HTFS_ASSERT_IMPL(a_check_full, clk, rst, state == ST_CHECK, fill == FULL)
  `HTFS_ASSERT_NEXT(a_slide, clk, rst, state == ST_CHECK && !match, fill == FULL - 1'b1)
  `HTFS_ASSERT_IMPL(a_last_index, clk, rst, m_tvalid && m_tlast, out_index == IW'(FRAME_BYTES - 1))
  `HTFS_ASSERT_NEXT(a_frame_done, clk, rst, load && idx_last, fill == '0 && oldest == '0)

endmodule

`default_nettype wire

// ===== rtl/core/header_trailer_frame_sync.sv =====
// Frame synchroniser for a received serial byte stream. Bytes enter through a
// four-deep queue, one per cycle while it has room, and move into a
// FRAME_BYTES-byte window at up to one per cycle until it is full. Then for
// each new byte the oldest byte is read from the window memory and compared
// with the header register, and the last two bytes, low byte first, with the
// trailer register, before the next byte is taken. On a mismatch the oldest
// byte is dropped; on a match the frame is read out byte by byte (window memory
// read, then the output register, held by any stall at the output), with the
// last byte marked by tlast. The input queue keeps taking bytes during a
// readout until it fills. Configuration is written with cfg_we, cfg_addr 0 for
// the header value and 1 for the trailer value.
// ----------------------------------------------------------------------------
// header_trailer_frame_sync
// Top level: configuration registers, input queue and window engine.
// ----------------------------------------------------------------------------
`default_nettype none

module header_trailer_frame_sync #(
  parameter int FRAME_BYTES = htfs_pkg::FRAME_BYTES_DEFAULT
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire  [htfs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire  [htfs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire  [htfs_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] rx_byte
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  output logic [htfs_pkg::TDATA_W-1:0]        m_tdata,   // [7:0] frame_byte, [13:8] byte_index
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic                                m_tlast    // last_of_frame
);

  htfs_pkg::cfg_t   cfg;
  htfs_pkg::qhead_t qhead;
  logic             q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_value  <= htfs_pkg::HEADER_RESET;
      cfg.trailer_value <= htfs_pkg::TRAILER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        htfs_pkg::REG_HEADER: begin
          cfg.header_value <= cfg_data[htfs_pkg::BYTE_W-1:0];
        end
        htfs_pkg::REG_TRAILER: begin
          cfg.trailer_value <= cfg_data[htfs_pkg::TRAIL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input queue
  htfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .q_pop    (q_pop),
    .qhead    (qhead)
  );

  // Window engine
  htfs_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .qhead    (qhead),
    .q_pop    (q_pop),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
